>>> rtl/sha_pkg.sv
// shared types, round constants and sigma functions for the sha-256 hasher
package sha_pkg;

  localparam int BlkWds = 16;
  localparam int HashWds = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  typedef struct packed {
    logic load_w;
    logic load_h;
    logic round;
    logic rotate;
  } rnd_ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_s0(input logic [31:0] x);
    sml_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_s1(input logic [31:0] x);
    sml_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] r;
    unique case (i)
      6'd0: r = 32'h428a2f98;   6'd1: r = 32'h71374491;
      6'd2: r = 32'hb5c0fbcf;   6'd3: r = 32'he9b5dba5;
      6'd4: r = 32'h3956c25b;   6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;   6'd7: r = 32'hab1c5ed5;
      6'd8: r = 32'hd807aa98;   6'd9: r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/sha_rnd.sv
// round unit: working variables and the sixteen-word schedule window
module sha_rnd (
  input  logic              clk,
  input  sha_pkg::rnd_ctl_t ctl,
  input  logic [31:0]       w_in,
  input  logic [31:0]       h_in,
  input  logic [31:0]       k_in,
  output logic [31:0]       a_out
);
  import sha_pkg::*;

  logic [31:0] v [HashWds];
  logic [31:0] w [BlkWds];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;

  always_comb begin
    t1 = v[7] + big_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_in + w[0];
    t2 = big_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_new = w[0] + sml_s0(w[1]) + w[9] + sml_s1(w[14]);
  end

  // schedule window shifts towards index 0
  always_ff @(posedge clk) begin
    if (ctl.load_w || ctl.round) begin
      for (int i = 0; i < BlkWds - 1; i++) w[i] <= w[i + 1];
      w[BlkWds - 1] <= ctl.load_w ? w_in : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_h) begin
      for (int i = 0; i < HashWds - 1; i++) v[i] <= v[i + 1];
      v[HashWds - 1] <= h_in;
    end else if (ctl.rotate) begin
      for (int i = 0; i < HashWds - 1; i++) v[i] <= v[i + 1];
      v[HashWds - 1] <= v[0];
    end else if (ctl.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  assign a_out = v[0];

endmodule

>>> rtl/sha256_stream_hasher.sv
// sha-256 stream hasher: byte intake, block and hash memories, control
// intake: a byte word is taken while the hasher is idle; a full block then stalls
// the input through load, rounds and hash update (through the hash memory)
// finish: the same states, again when a second padding block is needed, then a read
// and a load state per digest word; rate is set by the single round unit
// reset (rst, synchronous): initial hash values, empty buffer, zero length
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        func,
  input  logic [7:0]  data_byte,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha_pkg::*;

  state_t state, state_next;
  logic [5:0] cnt;

  // block buffer memory, one 32-bit word per entry
  logic [31:0] bmem [BlkWds];
  logic [31:0] brd;
  logic        b_we;
  logic [3:0]  b_waddr;
  logic [31:0] b_wdata;
  logic [3:0]  b_raddr;

  // hash word memory; entries without a valid bit read as the initial values
  logic [31:0] hmem [HashWds];
  logic [7:0]  hv;
  logic [31:0] hrd;
  logic        h_we;
  logic [2:0]  h_waddr;
  logic [31:0] h_wdata;
  logic [2:0]  h_raddr;
  logic        h_clr;

  // byte intake
  logic [5:0]  fill;
  logic [23:0] wacc;
  logic [63:0] msg_len;

  // padding control for the block being loaded
  logic        fin;
  logic        extra;
  logic        marker;
  logic        len_here;
  logic [4:0]  pad_pos;
  logic [31:0] pad_word;
  logic [31:0] pad_word_next;

  logic        take;
  logic        out_free;
  logic [3:0]  li;
  logic [31:0] w_in;
  logic [63:0] bits;
  logic [31:0] a_out;
  rnd_ctl_t    ctl;

  assign take     = item_valid && !item_stall;
  assign out_free = !digest_valid || !digest_stall;
  assign item_stall = (state != ST_IDLE);
  assign bits     = {msg_len[60:0], 3'b000};
  assign li       = 4'(cnt - 6'd1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take && (func || fill == 6'd63)) state_next = ST_LOAD;
      end
      ST_LOAD:  if (cnt == 6'd16) state_next = ST_ROUND;
      ST_ROUND: if (cnt == 6'd63) state_next = ST_ADD;
      ST_ADD: begin
        if (cnt == 6'd8) begin
          if (!fin)       state_next = ST_IDLE;
          else if (extra) state_next = ST_LOAD;
          else            state_next = ST_OUT_RD;
        end
      end
      ST_OUT_RD: state_next = ST_OUT_LD;
      ST_OUT_LD: begin
        if (out_free) state_next = (cnt == 6'd7) ? ST_IDLE : ST_OUT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory and round unit controls
  always_comb begin
    ctl     = '0;
    b_raddr = cnt[3:0];
    h_raddr = cnt[2:0];
    h_we    = 1'b0;
    h_waddr = li[2:0];
    h_wdata = hrd + a_out;
    h_clr   = 1'b0;
    b_we    = 1'b0;
    b_waddr = fill[5:2];
    b_wdata = {wacc, data_byte};
    unique case (state)
      ST_IDLE: b_we = take && !func && (fill[1:0] == 2'd3);
      ST_LOAD: begin
        ctl.load_w = (cnt != 6'd0);
        ctl.load_h = (cnt != 6'd0) && (cnt <= 6'd8);
      end
      ST_ROUND: ctl.round = 1'b1;
      ST_ADD: begin
        ctl.rotate = (cnt != 6'd0);
        h_we       = (cnt != 6'd0);
      end
      ST_OUT_RD: ;
      ST_OUT_LD: h_clr = out_free && (cnt == 6'd7);
      default: ;
    endcase
  end

  // schedule word: memory up to the pad point, then marker, zeros, length
  always_comb begin
    if ({1'b0, li} < pad_pos)       w_in = brd;
    else if ({1'b0, li} == pad_pos) w_in = marker ? pad_word : 32'h0;
    else if (len_here && li >= 4'd14) w_in = li[0] ? bits[31:0] : bits[63:32];
    else                            w_in = 32'h0;
  end

  // marker byte goes after the bytes already gathered in the partial word
  always_comb begin
    unique case (fill[1:0])
      2'd0: pad_word_next = 32'h80000000;
      2'd1: pad_word_next = {wacc[7:0], 8'h80, 16'h0};
      2'd2: pad_word_next = {wacc[15:0], 8'h80, 8'h0};
      default: pad_word_next = {wacc, 8'h80};
    endcase
  end

  sha_rnd u_rnd (
    .clk   (clk),
    .ctl   (ctl),
    .w_in  (w_in),
    .h_in  (hrd),
    .k_in  (round_k(cnt)),
    .a_out (a_out)
  );

  always_ff @(posedge clk) begin
    if (b_we) bmem[b_waddr] <= b_wdata;
    brd <= bmem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (h_we) hmem[h_waddr] <= h_wdata;
    hrd <= hv[h_raddr] ? hmem[h_raddr] : init_h(h_raddr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= '0;
    end else if (h_clr) begin
      hv <= '0;
    end else if (h_we) begin
      hv[h_waddr] <= 1'b1;
    end
  end

  // state and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_OUT_RD) cnt <= cnt;
      else if (state == ST_OUT_LD) cnt <= out_free ? cnt + 6'd1 : cnt;
      else if (state_next != state || (state == ST_ADD && state_next == ST_LOAD)) cnt <= '0;
      else if (state == ST_ADD && cnt == 6'd8) cnt <= '0;
      else if (state != ST_IDLE) cnt <= cnt + 6'd1;
      // digest readout starts from word zero
      if (state == ST_ADD && state_next == ST_OUT_RD) cnt <= '0;
    end
  end

  // byte intake, length and padding control
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      msg_len  <= '0;
      fin      <= 1'b0;
      extra    <= 1'b0;
      marker   <= 1'b0;
      len_here <= 1'b0;
      pad_pos  <= 5'd16;
    end else begin
      if (take && !func) begin
        wacc    <= {wacc[15:0], data_byte};
        fill    <= fill + 6'd1;
        msg_len <= msg_len + 64'd1;
        fin     <= 1'b0;
        pad_pos <= 5'd16;
        marker  <= 1'b0;
        len_here <= 1'b0;
        extra   <= 1'b0;
      end else if (take && func) begin
        fin      <= 1'b1;
        pad_pos  <= {1'b0, fill[5:2]};
        pad_word <= pad_word_next;
        marker   <= 1'b1;
        extra    <= (fill[5:3] == 3'b111);
        len_here <= (fill[5:3] != 3'b111);
        fill     <= '0;
      end
      // second padding block: zeros and the length only
      if (state == ST_ADD && cnt == 6'd8 && fin && extra) begin
        extra    <= 1'b0;
        marker   <= 1'b0;
        len_here <= 1'b1;
        pad_pos  <= 5'd0;
      end
      if (h_clr) msg_len <= '0;
    end
  end

  // digest output register
  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
    end else if (state == ST_OUT_LD && out_free) begin
      digest_valid <= 1'b1;
    end else if (!digest_stall) begin
      digest_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT_LD && out_free) begin
      digest_word <= hrd;
      word_index  <= cnt[2:0];
      last_word   <= (cnt == 6'd7);
    end
  end

`ifndef SYNTHESIS
  a_round_to_add: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && cnt == 6'd63) |=> (state == ST_ADD))
    else $error("round count did not end in hash update");

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last word flag disagrees with index");

  a_hash_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_LD && out_free && cnt == 6'd7) |=> (hv == 8'h00 && msg_len == 64'd0))
    else $error("hash state not restored after digest");
`endif

endmodule

>>> sim/tb_sha256_stream_hasher.sv
// testbench for the streaming sha-256 hasher: byte and finish words against a local digest model
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;

  // word codes on the func input
  localparam logic FN_ABSORB = 1'b0;
  localparam logic FN_FINISH = 1'b1;
  localparam int   MAX_CYCLES = 2_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        func = FN_ABSORB;
  logic [7:0]  data_byte = 8'h00;
  logic        digest_valid;
  logic        digest_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  always #1 clk = ~clk;

  sha256_stream_hasher dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .func(func), .data_byte(data_byte),
    .digest_valid(digest_valid), .digest_stall(digest_stall),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  // one expected digest word
  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_exp_t;

  digest_exp_t digest_q[$];

  // local copy of the hasher state
  logic [31:0] chain_h[8];
  logic [7:0]  msg_buf[64];
  int          buf_fill;
  logic [63:0] msg_len;

  int mismatches = 0;
  int digests_seen = 0;
  int words_sent = 0;
  int msgs_done = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;   // long receiver hold-off, driven by its own process
  bit finished = 1'b0;

  localparam logic [31:0] KTAB[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] IV[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] ror(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic restart_message();
    foreach (chain_h[i]) chain_h[i] = IV[i];
    buf_fill = 0;
    msg_len = '0;
  endtask

  // one 64-round compression of msg_buf into chain_h
  task automatic compress_buf();
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    {a, b, c, d, e, f, g, h} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
                                chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + KTAB[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endtask

  // advance the model by one accepted word, queueing any digest it produces
  task automatic predict_digest(logic fn, logic [7:0] byte_in);
    logic [63:0] bits;
    if (fn == FN_ABSORB) begin
      msg_buf[buf_fill] = byte_in;
      buf_fill++;
      msg_len++;
      if (buf_fill == 64) begin
        compress_buf();
        buf_fill = 0;
      end
    end else begin
      bits = msg_len << 3;
      msg_buf[buf_fill] = 8'h80;
      buf_fill++;
      if (buf_fill > 56) begin
        // length no longer fits, pad out an extra block
        for (int i = buf_fill; i < 64; i++) msg_buf[i] = 8'h00;
        compress_buf();
        buf_fill = 0;
      end
      for (int i = buf_fill; i < 56; i++) msg_buf[i] = 8'h00;
      for (int i = 0; i < 8; i++) msg_buf[63-i] = bits[8*i +: 8];
      compress_buf();
      for (int i = 0; i < 8; i++)
        digest_q.push_back('{word: chain_h[i], idx: 3'(i), last: (i == 7)});
      msgs_done++;
      restart_message();
    end
  endtask

  // sender: hold the word until it is taken, then update the model
  task automatic send_word(logic fn, logic [7:0] byte_in);
    func       <= fn;
    data_byte  <= byte_in;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    predict_digest(fn, byte_in);
    words_sent++;
  endtask

  task automatic idle_gap(int n);
    item_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_random_bytes(int n);
    for (int i = 0; i < n; i++) begin
      send_word(FN_ABSORB, 8'($urandom_range(0, 255)));
      // bursts with random gaps in between
      if ($urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 6));
    end
  endtask

  // directed: empty message, extreme bytes, "abc" and a restart after finish
  task automatic test_directed();
    send_word(FN_FINISH, 8'hff);                        // empty message
    send_word(FN_ABSORB, 8'h00);
    send_word(FN_ABSORB, 8'hff);
    send_word(FN_ABSORB, 8'haa);
    send_word(FN_ABSORB, 8'h55);
    send_word(FN_FINISH, 8'h00);
    send_word(FN_ABSORB, 8'h61); send_word(FN_ABSORB, 8'h62); send_word(FN_ABSORB, 8'h63);
    send_word(FN_FINISH, 8'h00);                        // "abc"
    send_word(FN_FINISH, 8'h5a);                        // message restarts after finish
    idle_gap(1);
  endtask

  // lengths around the single/double padding-block boundary and a full block
  task automatic test_pad_boundary();
    int lens[3] = '{55, 56, 64};
    foreach (lens[k]) begin
      send_random_bytes(lens[k]);
      send_word(FN_FINISH, 8'($urandom_range(0, 255)));
    end
    idle_gap(1);
  endtask

  // random short messages
  task automatic test_random_messages();
    int total = 0;
    while (total < 12) begin
      int n = $urandom_range(0, 6);
      send_random_bytes(n);
      send_word(FN_FINISH, 8'($urandom_range(0, 255)));
      total += n + 1;
    end
    idle_gap(1);
  endtask

  // receiver holds off while the sender keeps offering, so the input backs up
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int m = 0; m < 3; m++) begin
      send_random_bytes($urandom_range(1, 3));
      send_word(FN_FINISH, 8'h00);
    end
    idle_gap(1);
  endtask

  // long hold-off counted in cycles, released on its own
  initial begin
    wait (hold_off);
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  // receiver stall pattern: runs of stall and of no stall
  initial begin
    int run;
    @(negedge rst);
    forever begin
      run = $urandom_range(1, 30);
      for (int i = 0; i < run; i++) begin
        @(posedge clk);
        digest_stall <= hold_off || (i % 4 == 0 && run > 15)
                        || ($urandom_range(0, 9) < 2 && run < 8);
      end
      repeat ($urandom_range(0, 40)) begin
        @(posedge clk);
        digest_stall <= hold_off;
      end
    end
  end

  // digest checker: compare every accepted word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && digest_valid && !digest_stall) begin
      digests_seen++;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h idx %0d", digest_word, word_index);
      end else begin
        digest_exp_t e;
        e = digest_q.pop_front();
        if (digest_word !== e.word || word_index !== e.idx || last_word !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest word: exp %h/%0d/%0d got %h/%0d/%0d",
                     e.word, e.idx, e.last, digest_word, word_index, last_word);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES && !finished) begin
      $display("sha256_stream_hasher: mismatch");
      $finish;
    end
  end

  initial begin
    restart_message();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pad_boundary();
    test_backpressure();
    test_random_messages();
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    finished = 1'b1;
    $display("covered %0d words in %0d messages, %0d digest words checked",
             words_sent, msgs_done, digests_seen);
    if (mismatches == 0) begin
      $display("sha256_stream_hasher: match");
    end else begin
      $display("%0d digest words wrong", mismatches);
      $display("sha256_stream_hasher: mismatch");
    end
    $finish;
  end

endmodule
